// File: sv/btk_pkg.sv
`timescale 1ns / 1ps
// Shared constants and the command/status types of the best-times ranking list.
// Used by btk_ctrl, btk_datapath and best_times_top_k_insert.
package btk_pkg;

  localparam int LIST_DEPTH = 10;
  localparam int TIME_W     = 32;
  localparam int SLOT_W     = 4;
  localparam int RANK_W     = 4;
  localparam int SEL_W      = $clog2(LIST_DEPTH);
  localparam int POS_W      = $clog2(LIST_DEPTH + 1);

  typedef struct packed {
    logic             insert;
    logic             load;
    logic             last;
    logic [SEL_W-1:0] rd_idx;
  } btk_cmd_t;

  typedef struct packed {
    logic out_free;
  } btk_stat_t;

endpackage

// File: sv/best_times_top_k_insert.sv
`timescale 1ns / 1ps
// Top level of the best-times ranking list: joins controller and datapath.
// Depends on btk_pkg, btk_ctrl and btk_datapath.
//
// Keeps the ten smallest nonzero times in ascending order. Each beat on the
// input channel (time_ms, in_valid/in_ready) is ranked in the cycle it is
// accepted: it goes behind every entry that is smaller or equal, later
// entries move down one place and the last one drops out. A zero time or one
// that does not beat a full list leaves the list alone and reports placed=0
// with placed_rank=10.
// Every input is answered by a run of ten output beats (out_valid/out_ready),
// slots 0 to 9 in order, the final one flagged by is_last; placed and
// placed_rank repeat on every beat of the run.
// The item is ranked on acceptance; the controller then enters its read state
// and loads the slots through the single read port, one slot per cycle while
// the receiver takes each beat. in_ready is high only between runs, so the
// next item is taken once the last beat is loaded.
// A stalled receiver holds the run where it is; no beat is dropped.
// Reset (rst, synchronous) empties all slots and drops any beat in flight.
module best_times_top_k_insert (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [btk_pkg::TIME_W-1:0] time_ms,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [btk_pkg::SLOT_W-1:0] slot_index,
  output logic [btk_pkg::TIME_W-1:0] slot_time,
  output logic                       placed,
  output logic [btk_pkg::RANK_W-1:0] placed_rank,
  output logic                       is_last
);
  import btk_pkg::*;

  btk_cmd_t  cmd;
  btk_stat_t stat;

  btk_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  btk_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .time_ms     (time_ms),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .slot_index  (slot_index),
    .slot_time   (slot_time),
    .placed      (placed),
    .placed_rank (placed_rank),
    .is_last     (is_last)
  );

endmodule

// File: sv/btk_ctrl.sv
`timescale 1ns / 1ps
// Controller of the ranking list: takes one time, then walks the readout run.
// Depends on btk_pkg for the command and status types.
module btk_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output btk_pkg::btk_cmd_t cmd,
  input  btk_pkg::btk_stat_t stat
);
  import btk_pkg::*;

  typedef enum logic {S_IDLE, S_READ} state_t;

  state_t           state;
  logic [SEL_W-1:0] rd_idx;

  assign in_ready   = (state == S_IDLE);
  assign cmd.insert = in_valid && in_ready;
  assign cmd.load   = (state == S_READ) && stat.out_free;
  assign cmd.last   = (rd_idx == SEL_W'(LIST_DEPTH - 1));
  assign cmd.rd_idx = rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rd_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd.insert) begin
            state  <= S_READ;
            rd_idx <= '0;
          end
        end
        S_READ: begin
          if (cmd.load) begin
            if (cmd.last) begin
              state  <= S_IDLE;
              rd_idx <= '0;
            end else begin
              rd_idx <= rd_idx + SEL_W'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_insert_starts_run: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> (state == S_READ && rd_idx == '0))
    else $error("insert did not start a readout run at slot zero");

  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    rd_idx <= SEL_W'(LIST_DEPTH - 1))
    else $error("readout index beyond the list");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && cmd.last) |=> (state == S_IDLE))
    else $error("controller stayed busy after the last beat");

endmodule

// File: sv/btk_datapath.sv
`timescale 1ns / 1ps
// Datapath of the ranking list: slot registers, parallel compare and shift,
// and the output register. Depends on btk_pkg.
module btk_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  btk_pkg::btk_cmd_t            cmd,
  output btk_pkg::btk_stat_t           stat,
  input  logic [btk_pkg::TIME_W-1:0]   time_ms,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [btk_pkg::SLOT_W-1:0]   slot_index,
  output logic [btk_pkg::TIME_W-1:0]   slot_time,
  output logic                         placed,
  output logic [btk_pkg::RANK_W-1:0]   placed_rank,
  output logic                         is_last
);
  import btk_pkg::*;

  logic [TIME_W-1:0] best_times      [LIST_DEPTH];
  logic [TIME_W-1:0] best_times_next [LIST_DEPTH];
  logic [LIST_DEPTH-1:0] goes_here;
  logic [POS_W-1:0]  pos;
  logic              hit;
  logic              run_placed;
  logic [POS_W-1:0]  run_rank;
  logic              sorted_ok;

  // goes_here is a run of zeros followed by ones, because the list is sorted
  // and its empty slots sit at the tail; the first one marks the new slot.
  always_comb begin
    pos = '0;
    for (int k = 0; k < LIST_DEPTH; k++) begin
      goes_here[k] = (best_times[k] == '0) || (time_ms < best_times[k]);
      pos = pos + POS_W'(!goes_here[k]);
    end
    hit = (time_ms != '0) && (pos != POS_W'(LIST_DEPTH));
  end

  always_comb begin
    for (int k = 0; k < LIST_DEPTH; k++) begin
      if (!goes_here[k]) begin
        best_times_next[k] = best_times[k];
      end else if (k == 0 || !goes_here[(k == 0) ? 0 : k - 1]) begin
        best_times_next[k] = time_ms;
      end else begin
        best_times_next[k] = best_times[(k == 0) ? 0 : k - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LIST_DEPTH; k++) best_times[k] <= '0;
      run_placed <= 1'b0;
      run_rank   <= POS_W'(LIST_DEPTH);
    end else if (cmd.insert) begin
      if (hit) begin
        for (int k = 0; k < LIST_DEPTH; k++) best_times[k] <= best_times_next[k];
      end
      run_placed <= hit;
      run_rank   <= hit ? pos : POS_W'(LIST_DEPTH);
    end
  end

  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_index  <= SLOT_W'(cmd.rd_idx);
      slot_time   <= best_times[cmd.rd_idx];
      placed      <= run_placed;
      placed_rank <= RANK_W'(run_rank);
      is_last     <= cmd.last;
    end
  end

  always_comb begin
    sorted_ok = 1'b1;
    for (int k = 0; k < LIST_DEPTH - 1; k++) begin
      if (best_times[k + 1] != '0 &&
          (best_times[k] == '0 || best_times[k] > best_times[k + 1])) begin
        sorted_ok = 1'b0;
      end
    end
  end

  a_list_sorted: assert property (@(posedge clk) disable iff (rst) sorted_ok)
    else $error("ranking list lost its order or has a hole");

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> stat.out_free)
    else $error("output beat overwritten before it was taken");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_last) |-> (slot_index == SLOT_W'(LIST_DEPTH - 1)))
    else $error("last flag on a slot other than the final one");

endmodule
